/* sv/lesf_pkg.sv */
// Shared widths, reset values, register indexes and stage flags of the empty square finder.
package lesf_pkg;

  localparam int CHAR_W     = 8;
  localparam int SIZE_W     = 11;
  localparam int POS_W      = 10;
  localparam int ROWLEN_W   = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int OUT_DATA_W = 32;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam logic [CHAR_W-1:0]   EMPTY_CHAR_RST = 8'd46;
  localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RST = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CHAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'b1;

  // Control flags of one cell as it moves from the counter stage to the update stage.
  typedef struct packed {
    logic empty;     // cell matches the free character
    logic last;      // final cell of the grid
    logic active;    // row lies inside the grid store
    logic up_zero;   // first grid row, nothing above
    logic row_start; // cell opens a row after a row length change
    logic row_end;   // cell closes its row
  } cell_flags_t;

endpackage

/* sv/lesf_line_buf.sv */
// Line buffer holding the square sides of the previous grid row.
module lesf_line_buf #(
  parameter  int DEPTH = lesf_pkg::DEF_MAX_COLS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lesf_pkg::SIZE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [lesf_pkg::SIZE_W-1:0] rd_data
);

  logic [lesf_pkg::SIZE_W-1:0] mem [DEPTH];
  logic [lesf_pkg::SIZE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read that meets a write to the same entry returns the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/lesf_cell_ctrl.sv */
// Input stage: row and column counters, line buffer read request and the cell register.
module lesf_cell_ctrl #(
  parameter  int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter  int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS,
  localparam int CIW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RIW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lesf_pkg::CHAR_W-1:0]   cell_char,
  input  logic                          last_cell,
  input  logic [lesf_pkg::CHAR_W-1:0]   empty_char,
  input  logic [lesf_pkg::ROWLEN_W-1:0] row_length,
  input  logic                          dp_fire,
  output logic                          rd_en,
  output logic [CIW-1:0]                rd_addr,
  output logic                          s1_valid,
  output lesf_pkg::cell_flags_t         s1_flags,
  output logic [CIW-1:0]                s1_col,
  output logic [RIW-1:0]                s1_row
);

  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);

  logic [CCW-1:0] col_count_r, col_count_nxt;
  logic [RCW-1:0] row_count_r, row_count_nxt;
  logic           s1_valid_r, s1_valid_nxt;
  lesf_pkg::cell_flags_t flags_r;
  logic [CIW-1:0] col_r;
  logic [RIW-1:0] row_r;

  logic [CCW-1:0] eff_len;
  logic           accept;
  logic           pre_wrap;
  logic           wrap;
  logic [CCW-1:0] col0;
  logic [CCW-1:0] col1;
  logic [RCW-1:0] row0;
  logic [RCW-1:0] row_cur_inc;
  logic [RCW-1:0] row0_inc;
  lesf_pkg::cell_flags_t flags_nxt;

  // A zero row length acts as one; anything above the store acts as the full store.
  always_comb begin
    if (row_length == '0) begin
      eff_len = CCW'(1);
    end else if (32'(row_length) > 32'(MAX_COLS)) begin
      eff_len = CCW'(MAX_COLS);
    end else begin
      eff_len = CCW'(row_length);
    end
  end

  assign in_tready = !s1_valid_r || dp_fire;
  assign accept    = in_tvalid && in_tready;

  assign row_cur_inc = (row_count_r < RCW'(MAX_ROWS)) ? row_count_r + RCW'(1) : row_count_r;

  always_comb begin
    pre_wrap = (col_count_r >= eff_len);
    col0     = pre_wrap ? '0 : col_count_r;
    row0     = pre_wrap ? row_cur_inc : row_count_r;
    row0_inc = (row0 < RCW'(MAX_ROWS)) ? row0 + RCW'(1) : row0;
    col1     = col0 + CCW'(1);
    wrap     = (col1 >= eff_len);

    flags_nxt.empty     = (cell_char == empty_char);
    flags_nxt.last      = last_cell;
    flags_nxt.active    = (row0 < RCW'(MAX_ROWS));
    flags_nxt.up_zero   = (row0 == '0);
    flags_nxt.row_start = pre_wrap;
    flags_nxt.row_end   = wrap;

    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (accept) begin
      if (last_cell) begin
        col_count_nxt = '0;
        row_count_nxt = '0;
      end else if (wrap) begin
        col_count_nxt = '0;
        row_count_nxt = row0_inc;
      end else begin
        col_count_nxt = col1;
        row_count_nxt = row0;
      end
    end

    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (dp_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flags_r <= flags_nxt;
      col_r   <= col0[CIW-1:0];
      row_r   <= row0[RIW-1:0];
    end
  end

  assign rd_en    = accept;
  assign rd_addr  = col0[CIW-1:0];
  assign s1_valid = s1_valid_r;
  assign s1_flags = flags_r;
  assign s1_col   = col_r;
  assign s1_row   = row_r;

endmodule

/* sv/lesf_dp_core.sv */
// Update stage: square side recurrence, best square tracking and the result register.
module lesf_dp_core #(
  parameter  int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter  int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS,
  localparam int CIW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RIW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  lesf_pkg::cell_flags_t       s1_flags,
  input  logic [CIW-1:0]              s1_col,
  input  logic [RIW-1:0]              s1_row,
  input  logic [lesf_pkg::SIZE_W-1:0] up_data,
  output logic                        dp_fire,
  output logic                        wr_en,
  output logic [CIW-1:0]              wr_addr,
  output logic [lesf_pkg::SIZE_W-1:0] wr_data,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lesf_pkg::SIZE_W-1:0] square_size,
  output logic [lesf_pkg::POS_W-1:0]  top_row,
  output logic [lesf_pkg::POS_W-1:0]  left_col
);

  localparam int SW  = lesf_pkg::SIZE_W;
  localparam int PW  = lesf_pkg::POS_W;

  logic [SW-1:0] left_r, left_nxt;
  logic [SW-1:0] upleft_r, upleft_nxt;
  logic [SW-1:0] best_size_r, best_size_nxt;
  logic [PW-1:0] best_row_r, best_row_nxt;
  logic [PW-1:0] best_col_r, best_col_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [PW-1:0] top_r, top_nxt;
  logic [PW-1:0] lcol_r, lcol_nxt;

  logic [SW-1:0] up;
  logic [SW-1:0] left_base;
  logic [SW-1:0] upleft_base;
  logic [SW-1:0] m;
  logic [SW-1:0] side;
  logic [SW-1:0] top_wide;
  logic [SW-1:0] lcol_wide;

  // A last cell can only move on when the result register is free.
  assign dp_fire = s1_valid && (!s1_flags.last || !out_valid_r || out_tready);

  always_comb begin
    up          = s1_flags.up_zero ? '0 : up_data;
    left_base   = s1_flags.row_start ? '0 : left_r;
    upleft_base = s1_flags.row_start ? '0 : upleft_r;

    m = up;
    if (left_base < m) begin
      m = left_base;
    end
    if (upleft_base < m) begin
      m = upleft_base;
    end
    side = s1_flags.empty ? m + SW'(1) : '0;

    left_nxt      = left_r;
    upleft_nxt    = upleft_r;
    best_size_nxt = best_size_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;

    if (dp_fire) begin
      left_nxt   = left_base;
      upleft_nxt = upleft_base;
      if (s1_flags.active) begin
        left_nxt   = side;
        upleft_nxt = up;
        // Strictly larger only, so the earliest top-left corner wins a tie.
        if (side > best_size_r) begin
          best_size_nxt = side;
          best_row_nxt  = PW'(s1_row);
          best_col_nxt  = PW'(s1_col);
        end
      end
      if (s1_flags.row_end || s1_flags.last) begin
        left_nxt   = '0;
        upleft_nxt = '0;
      end
    end

    top_wide  = SW'(best_row_nxt) + SW'(1) - best_size_nxt;
    lcol_wide = SW'(best_col_nxt) + SW'(1) - best_size_nxt;
    if (best_size_nxt == '0) begin
      size_nxt = '0;
      top_nxt  = '0;
      lcol_nxt = '0;
    end else begin
      size_nxt = best_size_nxt;
      top_nxt  = top_wide[PW-1:0];
      lcol_nxt = lcol_wide[PW-1:0];
    end

    if (dp_fire && s1_flags.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      upleft_r    <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r      <= left_nxt;
      upleft_r    <= upleft_nxt;
      out_valid_r <= out_valid_nxt;
      if (dp_fire && s1_flags.last) begin
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        best_size_r <= best_size_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_fire && s1_flags.last) begin
      size_r <= size_nxt;
      top_r  <= top_nxt;
      lcol_r <= lcol_nxt;
    end
  end

  assign wr_en       = dp_fire && s1_flags.active;
  assign wr_addr     = s1_col;
  assign wr_data     = side;
  assign out_tvalid  = out_valid_r;
  assign square_size = size_r;
  assign top_row     = top_r;
  assign left_col    = lcol_r;

endmodule

/* sv/largest_empty_square_finder.sv */
// The last cell passes the cell register and then the update stage before out_tvalid rises.
// Throughput: one cell per cycle, bounded by the single read and write port of the line buffer,
// except when a held result stalls it, which happens only if the waiting cell is a last cell.
// Reset is synchronous and active low; it clears counters, running sides and best square and
// returns the configuration to its defaults. The line buffer is not cleared.
module largest_empty_square_finder #(
  parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] cell_char
  input  logic                              in_tlast,   // last_cell
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lesf_pkg::OUT_DATA_W-1:0]   out_tdata,  // [10:0] square_size,
                                                        // [20:11] top_row, [30:21] left_col
  input  logic                              cfg_wr_en,
  input  logic [lesf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lesf_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [lesf_pkg::CHAR_W-1:0]   empty_char_r;
  logic [lesf_pkg::ROWLEN_W-1:0] row_length_r;

  logic                        rd_en;
  logic [CIW-1:0]              rd_addr;
  logic [lesf_pkg::SIZE_W-1:0] rd_data;
  logic                        wr_en;
  logic [CIW-1:0]              wr_addr;
  logic [lesf_pkg::SIZE_W-1:0] wr_data;
  logic                        s1_valid;
  lesf_pkg::cell_flags_t       s1_flags;
  logic [CIW-1:0]              s1_col;
  logic [RIW-1:0]              s1_row;
  logic                        dp_fire;
  logic [lesf_pkg::SIZE_W-1:0] square_size;
  logic [lesf_pkg::POS_W-1:0]  top_row;
  logic [lesf_pkg::POS_W-1:0]  left_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_char_r <= lesf_pkg::EMPTY_CHAR_RST;
      row_length_r <= lesf_pkg::ROW_LENGTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lesf_pkg::CFG_EMPTY_CHAR: empty_char_r <= cfg_wr_data[lesf_pkg::CHAR_W-1:0];
        lesf_pkg::CFG_ROW_LENGTH: row_length_r <= cfg_wr_data[lesf_pkg::ROWLEN_W-1:0];
        default: ;
      endcase
    end
  end

  lesf_cell_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cell_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cell_char  (in_tdata[lesf_pkg::CHAR_W-1:0]),
    .last_cell  (in_tlast),
    .empty_char (empty_char_r),
    .row_length (row_length_r),
    .dp_fire    (dp_fire),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .s1_valid   (s1_valid),
    .s1_flags   (s1_flags),
    .s1_col     (s1_col),
    .s1_row     (s1_row)
  );

  lesf_line_buf #(
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lesf_dp_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_flags    (s1_flags),
    .s1_col      (s1_col),
    .s1_row      (s1_row),
    .up_data     (rd_data),
    .dp_fire     (dp_fire),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .square_size (square_size),
    .top_row     (top_row),
    .left_col    (left_col)
  );

  assign out_tdata = {1'b0, left_col, top_row, square_size};

`ifndef SYNTHESIS
  // A result only appears after a last cell has left the update stage.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(dp_fire && s1_flags.last))
    else $error("result raised without a last cell");

  // A cell held in the update stage must block the next request.
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !dp_fire) |-> !in_tready)
    else $error("request accepted while the update stage is held");

  // An empty result reports its corner at the origin.
  a_empty_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (square_size == '0)) |-> ((top_row == '0) && (left_col == '0)))
    else $error("zero size result with a non-zero corner");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for largest_empty_square_finder: directed grids, then random grids.
`timescale 1ns / 1ps
module tb_top;
  import lesf_pkg::*;

  localparam int COLS_MAX        = DEF_MAX_COLS;
  localparam int ROWS_MAX        = DEF_MAX_ROWS;
  localparam int SETTLE          = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_CELLS    = 400;
  localparam int GRID_CAP        = 160;
  localparam int TIMEOUT_NS      = 8_000_000;

  typedef struct packed {
    logic [SIZE_W-1:0] side;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
  } square_t;

  typedef enum logic {STEP_CELL, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  value;  // register data, or the cell character in the low bits
    logic                   last;
    bit                     typed;
    square_t                want;
  } step_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  // Predictor state.
  logic [CHAR_W-1:0]   free_char   = EMPTY_CHAR_RST;
  logic [ROWLEN_W-1:0] row_len_reg = ROW_LENGTH_RST;
  logic [SIZE_W-1:0]   line_sides [0:COLS_MAX-1];
  int unsigned         left_side, diag_side, col_pos, row_pos;
  int unsigned         best_side, best_row, best_col;

  square_t pending_squares[$];
  step_t   directed_steps[$];
  int      errors      = 0;
  bit      sender_calm = 1'b0;
  bit      sink_calm   = 1'b0;
  bit      hold_burst  = 1'b0;

  largest_empty_square_finder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("largest_empty_square_finder test failed");
    $finish;
  end

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  function automatic int unsigned span();
    if (row_len_reg == 0) return 1;
    if (row_len_reg > COLS_MAX) return COLS_MAX;
    return 32'(row_len_reg);
  endfunction

  function automatic void start_row();
    col_pos   = 0;
    left_side = 0;
    diag_side = 0;
    if (row_pos < ROWS_MAX) row_pos++;
  endfunction

  // Advances the predictor by one cell; returns 1 with the square when the grid ends.
  function automatic bit predict_cell(input logic [CHAR_W-1:0] ch, input logic last,
                                      output square_t sq);
    int unsigned len, up, side, m;
    len = span();
    sq  = '0;
    if (col_pos >= len) start_row();
    if (row_pos < ROWS_MAX) begin
      up   = (row_pos == 0) ? 0 : 32'(line_sides[col_pos % COLS_MAX]);
      side = 0;
      if (ch == free_char) begin
        m = up;
        if (left_side < m) m = left_side;
        if (diag_side < m) m = diag_side;
        side = (m + 1) & 32'h7FF;
      end
      diag_side = up;
      left_side = side;
      line_sides[col_pos % COLS_MAX] = SIZE_W'(side);
      if (side > best_side) begin
        best_side = side;
        best_row  = row_pos & 32'h3FF;
        best_col  = (col_pos % COLS_MAX) & 32'h3FF;
      end
    end
    col_pos++;
    if (col_pos >= len) start_row();
    if (!last) return 1'b0;
    if (best_side != 0) begin
      sq.side = SIZE_W'(best_side);
      sq.row  = POS_W'(best_row + 1 - best_side);
      sq.col  = POS_W'(best_col + 1 - best_side);
    end
    left_side = 0;
    diag_side = 0;
    col_pos   = 0;
    row_pos   = 0;
    best_side = 0;
    best_row  = 0;
    best_col  = 0;
    return 1'b1;
  endfunction

  function automatic void add_cell(logic [CHAR_W-1:0] ch, logic last);
    step_t s;
    s.kind  = STEP_CELL;
    s.idx   = CFG_EMPTY_CHAR;
    s.value = CFG_DATA_W'(ch);
    s.last  = last;
    s.typed = 1'b0;
    s.want  = '0;
    directed_steps.push_back(s);
  endfunction

  // A grid-closing cell whose square is known by inspection.
  function automatic void add_typed(logic [CHAR_W-1:0] ch, int side, int row, int col);
    step_t s;
    s.kind      = STEP_CELL;
    s.idx       = CFG_EMPTY_CHAR;
    s.value     = CFG_DATA_W'(ch);
    s.last      = 1'b1;
    s.typed     = 1'b1;
    s.want.side = SIZE_W'(side);
    s.want.row  = POS_W'(row);
    s.want.col  = POS_W'(col);
    directed_steps.push_back(s);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    step_t s;
    s.kind  = STEP_REG;
    s.idx   = idx;
    s.value = value;
    s.last  = 1'b0;
    s.typed = 1'b0;
    s.want  = '0;
    directed_steps.push_back(s);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_row_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'($urandom_range(COLS_MAX + 1, 2047));
    if (r == 2) return CFG_DATA_W'(COLS_MAX);
    if (r < 5) return CFG_DATA_W'($urandom_range(11, 64));
    return CFG_DATA_W'($urandom_range(1, 10));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_cell(int density);
    if ($urandom_range(1, 100) <= density) return free_char;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Lowers the request and waits until the block has nothing left in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_EMPTY_CHAR) free_char = value[CHAR_W-1:0];
    else row_len_reg = value;
  endtask

  task automatic send_cell(logic [CHAR_W-1:0] ch, logic last, bit typed, square_t want);
    int      gap;
    square_t sq;
    gap = sender_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (predict_cell(ch, last, sq)) pending_squares.push_back(typed ? want : sq);
  endtask

  // Result side: random stalls, one long hold-off on request, field-by-field comparison.
  initial begin
    int                 stall;
    square_t            want;
    logic [SIZE_W-1:0]  got_side;
    logic [POS_W-1:0]   got_row, got_col;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_burst) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_burst = 1'b0;
        stall = 0;
      end else begin
        if ($urandom_range(0, 15) == 0) sink_calm = !sink_calm;
        stall = sink_calm ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got_side = out_tdata[10:0];
      got_row  = out_tdata[20:11];
      got_col  = out_tdata[30:21];
      if (pending_squares.size() == 0) begin
        flag_mismatch("unexpected result, square_size", 'x, 32'(got_side));
      end else begin
        want = pending_squares.pop_front();
        if (got_side !== want.side)
          flag_mismatch("square_size", 32'(want.side), 32'(got_side));
        if (got_row !== want.row) flag_mismatch("top_row", 32'(want.row), 32'(got_row));
        if (got_col !== want.col) flag_mismatch("left_col", 32'(want.col), 32'(got_col));
      end
    end
  end

  initial begin
    int                density, ncells, cap, cut, random_cells;
    logic [CHAR_W-1:0] ch;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= CFG_EMPTY_CHAR;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    foreach (line_sides[i]) line_sides[i] = '0;
    left_side = 0;
    diag_side = 0;
    col_pos   = 0;
    row_pos   = 0;
    best_side = 0;
    best_row  = 0;
    best_col  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: a lone full cell, then a lone free cell.
    add_typed(8'h00, 0, 0, 0);
    add_typed(8'd46, 1, 0, 0);
    add_reg(CFG_ROW_LENGTH, 11'd2);
    add_cell(8'd46, 1'b0);
    add_cell(8'd46, 1'b0);
    add_cell(8'd46, 1'b0);
    add_typed(8'd46, 2, 0, 0);
    // A zero row length behaves as one; equal squares keep the earliest.
    add_reg(CFG_EMPTY_CHAR, 8'hFF);
    add_reg(CFG_ROW_LENGTH, 11'd0);
    add_cell(8'hFF, 1'b0);
    add_cell(8'd46, 1'b0);
    add_typed(8'hFF, 1, 0, 0);
    // An oversized row length behaves as the widest row.
    add_reg(CFG_EMPTY_CHAR, 8'h00);
    add_reg(CFG_ROW_LENGTH, 11'd2047);
    add_cell(8'hFF, 1'b0);
    add_typed(8'h00, 1, 0, 1);
    // Ties among 2x2 squares, then the row length shrinks in mid-grid.
    add_reg(CFG_ROW_LENGTH, 11'd4);
    for (int i = 0; i < 11; i++) add_cell((i == 4) ? 8'h07 : 8'h00, 1'b0);
    add_reg(CFG_ROW_LENGTH, 11'd2);
    add_cell(8'h00, 1'b0);
    add_cell(8'h00, 1'b1);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_REG) begin
        drain();
        write_reg(directed_steps[i].idx, directed_steps[i].value);
      end else begin
        send_cell(directed_steps[i].value[CHAR_W-1:0], directed_steps[i].last,
                  directed_steps[i].typed, directed_steps[i].want);
      end
    end

    // Back-to-back single-cell grids against a long receiver hold-off fill the block.
    drain();
    hold_burst  = 1'b1;
    sender_calm = 1'b1;
    for (int i = 0; i < 40; i++) send_cell(pick_cell(60), 1'b1, 1'b0, '0);
    sender_calm = 1'b0;

    // One column taller than the row store: only the cells from the last stored row on are free.
    drain();
    write_reg(CFG_ROW_LENGTH, 11'd1);
    for (int i = 0; i < ROWS_MAX + 6; i++) begin
      ch = (i >= ROWS_MAX - 1) ? free_char : free_char + 8'd1;
      send_cell(ch, i == ROWS_MAX + 5, 1'b0, '0);
    end

    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        if ($urandom_range(0, 1) == 1)
          write_reg(CFG_EMPTY_CHAR, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(CFG_ROW_LENGTH, pick_row_length());
      end
      if ($urandom_range(0, 3) == 0) sender_calm = !sender_calm;
      density = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(50, 95);
      cap = $urandom_range(1, 8) * span();
      if (cap > GRID_CAP) cap = GRID_CAP;
      ncells = $urandom_range(1, cap);
      cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, ncells) : 0;
      for (int k = 0; k < ncells; k++) begin
        // Mid-grid changes never lengthen the row, so no unwritten store entry is read.
        if (k == cut && k > 0) begin
          drain();
          if ($urandom_range(0, 1) == 1)
            write_reg(CFG_EMPTY_CHAR, CFG_DATA_W'($urandom_range(0, 255)));
          write_reg(CFG_ROW_LENGTH, CFG_DATA_W'($urandom_range(0, span())));
        end
        send_cell(pick_cell(density), k == ncells - 1, 1'b0, '0);
        random_cells++;
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("largest_empty_square_finder test passed");
    end else begin
      $display("largest_empty_square_finder test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lesf_pkg.sv
sv/lesf_line_buf.sv
sv/lesf_cell_ctrl.sv
sv/lesf_dp_core.sv
sv/largest_empty_square_finder.sv
test/tb_top.sv
